/* src/one_off_pattern_occurrence_counter_top_assert.svh */
// Assertion macros for the one-off pattern occurrence counter.
`ifndef ONE_OFF_PATTERN_OCCURRENCE_COUNTER_TOP_ASSERT_SVH
`define ONE_OFF_PATTERN_OCCURRENCE_COUNTER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define OPOC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("opoc check failed");
`define OPOC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("opoc check failed");
`else
`define OPOC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OPOC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/opoc_pkg.sv */
// Package with the shared constants of the one-off pattern occurrence counter.
`default_nettype none
package opoc_pkg;
  localparam int MaxPattern  = 16;
  localparam int MaxSequence = 1024;
  localparam int PosW        = $clog2(MaxSequence);
  localparam int CntW        = PosW + 1;
  localparam int PatIdxW     = $clog2(MaxPattern);
  localparam int LenW        = 5;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 64;

  localparam logic [CfgIdxW-1:0] CfgPatternLength    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternCharsLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatternCharsHigh = 2'd2;
endpackage
`default_nettype wire

/* src/opoc_if.sv */
// Handshake channel interfaces of the one-off pattern occurrence counter.
`default_nettype none
interface opoc_in_if import opoc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface opoc_out_if import opoc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CntW-1:0] occurrence_count;
  logic            found;
  logic            overflow;
  logic            is_last;
  modport source (output valid, output occurrence_count, output found, output overflow,
                  output is_last, input ready);
  modport sink   (input valid, input occurrence_count, input found, input overflow,
                  input is_last, output ready);
endinterface

interface opoc_cfg_if import opoc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/one_off_pattern_occurrence_counter_top.sv */
// Top level of the one-off pattern occurrence counter.
// The block takes a byte sequence on in_i (symbol, last) and returns one item per byte
// on out_o: the running one-off occurrence count, whether an occurrence completed at
// this byte, an overflow flag for bytes past 1024 positions, and an echo of last.
// The user must write the pattern (length and up to 16 characters) on cfg_i only
// while idle, unchecked by the block. cfg_i is always ready and index 3 is ignored.
// One byte is handled at a time. Per pattern position the logic reads the candidate
// FIFO front, then the used-position map, each a registered memory read, decides on a
// pop, and then decides on the push; each pop repeats the reads and the pop decision,
// and an empty FIFO skips them. To mark an occurrence, the used map is then read and
// written for each pattern position. A byte past the maximum length goes straight from
// entry to the result handoff.
// After a byte marked last, the used map is cleared one entry per cycle over the
// positions the sequence reached (at most 1024 entries), during which in_i is not ready.
// After reset the same clearing pass runs over all 1024 entries.
// A result waits in the output register while out_o is stalled; the next byte is
// accepted meanwhile and is held until the register frees.
`default_nettype none
`include "one_off_pattern_occurrence_counter_top_assert.svh"
module one_off_pattern_occurrence_counter_top import opoc_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  opoc_in_if.sink     in_i,
  opoc_out_if.source  out_o,
  opoc_cfg_if.sink    cfg_i
);
  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_FRONT, ST_USED, ST_DEC, ST_PUSH, ST_MREAD, ST_MWRITE, ST_OUT
  } state_e;

  state_e              state_q;
  logic [LenW-1:0]     len_q;
  logic [63:0]         chars_lo_q, chars_hi_q;
  logic [CntW-1:0]     pos_q, count_q;
  logic [CntW-1:0]     head_q [MaxPattern];
  logic [CntW-1:0]     tail_q [MaxPattern];
  logic [PatIdxW-1:0]  m_q;
  logic [7:0]          sym_q;
  logic                last_q, ovf_q, found_q, all_q;
  logic                prev_has_q, cur_has_q;
  logic [PosW-1:0]     prev_front_q, cur_front_q, front_q;
  logic [CntW-1:0]     sweep_q, sweep_end_q;
  logic                out_valid_q, out_found_q, out_ovf_q, out_last_q;
  logic [CntW-1:0]     out_count_q;

  logic [PatIdxW+PosW-1:0] fifo_raddr, fifo_waddr;
  logic [PosW-1:0]         fifo_rdata;
  logic                    fifo_we;
  logic [PosW-1:0]         used_addr;
  logic                    used_we, used_wdata, used_rdata;
  logic [LenW-1:0]         len_eff;
  logic [PatIdxW-1:0]      last_m;
  logic [63:0]             char_word;
  logic [7:0]              char_m;
  logic                    has_m, pop, push, new_has;
  logic [PosW-1:0]         new_front, pos_k;
  logic [CntW-1:0]         pos_next;

  // Effective pattern length and the character at the current position.
  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > LenW'(MaxPattern)) begin
      len_eff = LenW'(MaxPattern);
    end else begin
      len_eff = len_q;
    end
    last_m    = PatIdxW'(len_eff - LenW'(1));
    char_word = m_q[PatIdxW-1] ? chars_hi_q : chars_lo_q;
    char_m    = char_word[{m_q[2:0], 3'b000} +: 8];
    pos_k     = pos_q[PosW-1:0];
    pos_next  = ovf_q ? pos_q : pos_q + CntW'(1);
  end

  // Pop and push decisions for the current pattern position.
  always_comb begin
    has_m = head_q[m_q] < tail_q[m_q];
    pop   = used_rdata ||
            ((m_q != '0) && prev_has_q && (front_q <= prev_front_q));
    push  = (sym_q == char_m) && !tail_q[m_q][PosW] &&
            ((m_q == '0) || (prev_has_q && (pos_k > prev_front_q)));
    new_has   = cur_has_q || push;
    new_front = cur_has_q ? cur_front_q : pos_k;
  end

  // Memory port controls.
  always_comb begin
    fifo_raddr = {m_q, head_q[m_q][PosW-1:0]};
    fifo_waddr = {m_q, tail_q[m_q][PosW-1:0]};
    fifo_we    = (state_q == ST_PUSH) && push;
    used_we    = 1'b0;
    used_wdata = 1'b0;
    used_addr  = fifo_rdata;
    case (state_q)
      ST_SWEEP: begin
        used_we   = 1'b1;
        used_addr = sweep_q[PosW-1:0];
      end
      ST_MWRITE: begin
        used_we    = 1'b1;
        used_wdata = 1'b1;
      end
      default: begin
        used_we = 1'b0;
      end
    endcase
  end

  opoc_ram #(.Width(PosW), .Depth(MaxPattern * MaxSequence)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (pos_k),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  opoc_ram #(.Width(1), .Depth(MaxSequence)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_addr),
    .wdata_i (used_wdata),
    .raddr_i (used_addr),
    .rdata_o (used_rdata)
  );

  assign in_i.ready              = (state_q == ST_IDLE);
  assign cfg_i.ready             = 1'b1;
  assign out_o.valid             = out_valid_q;
  assign out_o.occurrence_count  = out_count_q;
  assign out_o.found             = out_found_q;
  assign out_o.overflow          = out_ovf_q;
  assign out_o.is_last           = out_last_q;

  // Sequencer: state, configuration, FIFO pointers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      len_q        <= LenW'(1);
      chars_lo_q   <= '0;
      chars_hi_q   <= '0;
      pos_q        <= '0;
      count_q      <= '0;
      for (int i = 0; i < MaxPattern; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      m_q          <= '0;
      sym_q        <= '0;
      last_q       <= 1'b0;
      ovf_q        <= 1'b0;
      found_q      <= 1'b0;
      all_q        <= 1'b0;
      prev_has_q   <= 1'b0;
      cur_has_q    <= 1'b0;
      prev_front_q <= '0;
      cur_front_q  <= '0;
      front_q      <= '0;
      sweep_q      <= '0;
      sweep_end_q  <= CntW'(MaxSequence);
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_ovf_q    <= 1'b0;
      out_last_q   <= 1'b0;
      out_count_q  <= '0;
    end else begin
      // Configuration writes.
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CfgPatternLength:    len_q      <= cfg_i.data[LenW-1:0];
          CfgPatternCharsLow:  chars_lo_q <= cfg_i.data;
          CfgPatternCharsHigh: chars_hi_q <= cfg_i.data;
          default:             len_q      <= len_q;
        endcase
      end
      // The receiver took the result; in ST_OUT the output register is handled below.
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_SWEEP: begin
          sweep_q <= sweep_q + CntW'(1);
          if (sweep_q + CntW'(1) == sweep_end_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            sym_q      <= in_i.symbol;
            last_q     <= in_i.last;
            ovf_q      <= pos_q[PosW];
            found_q    <= 1'b0;
            all_q      <= 1'b1;
            m_q        <= '0;
            prev_has_q <= 1'b0;
            state_q    <= pos_q[PosW] ? ST_OUT : ST_FRONT;
          end
        end
        ST_FRONT: begin
          if (has_m) begin
            state_q <= ST_USED;
          end else begin
            cur_has_q <= 1'b0;
            state_q   <= ST_PUSH;
          end
        end
        ST_USED: begin
          front_q <= fifo_rdata;
          state_q <= ST_DEC;
        end
        ST_DEC: begin
          if (pop) begin
            head_q[m_q] <= head_q[m_q] + CntW'(1);
            state_q     <= ST_FRONT;
          end else begin
            cur_has_q   <= 1'b1;
            cur_front_q <= front_q;
            state_q     <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push) begin
            tail_q[m_q] <= tail_q[m_q] + CntW'(1);
          end
          prev_has_q   <= new_has;
          prev_front_q <= new_front;
          all_q        <= all_q && new_has;
          if (m_q == last_m) begin
            m_q     <= '0;
            state_q <= (all_q && new_has) ? ST_MREAD : ST_OUT;
          end else begin
            m_q     <= m_q + PatIdxW'(1);
            state_q <= ST_FRONT;
          end
        end
        ST_MREAD: begin
          state_q <= ST_MWRITE;
        end
        ST_MWRITE: begin
          if (m_q == last_m) begin
            count_q <= count_q + CntW'(1);
            found_q <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            m_q     <= m_q + PatIdxW'(1);
            state_q <= ST_MREAD;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_count_q <= count_q;
            out_found_q <= found_q;
            out_ovf_q   <= ovf_q;
            out_last_q  <= last_q;
            if (last_q) begin
              pos_q   <= '0;
              count_q <= '0;
              for (int i = 0; i < MaxPattern; i++) begin
                head_q[i] <= '0;
                tail_q[i] <= '0;
              end
              sweep_q     <= '0;
              sweep_end_q <= pos_next;
              state_q     <= (pos_next == '0) ? ST_IDLE : ST_SWEEP;
            end else begin
              pos_q   <= pos_next;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Consistency checks.
  `OPOC_ASSERT_IMP(a_found_no_ovf, clk_i, rst_ni, out_valid_q && out_found_q, !out_ovf_q)
  `OPOC_ASSERT_IMP(a_found_count, clk_i, rst_ni, out_valid_q && out_found_q, out_count_q != '0)
  `OPOC_ASSERT_IMP(a_head_le_tail, clk_i, rst_ni, 1'b1, head_q[m_q] <= tail_q[m_q])
  `OPOC_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
endmodule
`default_nettype wire

/* src/opoc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module opoc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the one-off pattern occurrence counter.
`timescale 1ns / 100ps
module testbench;
  import opoc_pkg::*;

  // One expected result item of the block.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            found;
    logic            overflow;
    logic            is_last;
  } tally_t;

  // One row of the directed plan: a register write or a byte.
  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [7:0]          sym;
    bit                  last;
    bit                  typed;
    tally_t              want;
  } plan_row_t;

  localparam int WatchLimit = 300000;
  localparam int DrainWait  = 1100;

  logic clk_i;
  logic rst_ni;

  opoc_in_if  in_ch ();
  opoc_out_if out_ch ();
  opoc_cfg_if cfg_ch ();

  one_off_pattern_occurrence_counter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  // Predictor state: pattern registers and per-sequence matching state.
  logic [LenW-1:0]     pat_len;
  logic [CfgDataW-1:0] pat_low;
  logic [CfgDataW-1:0] pat_high;
  logic [PosW-1:0]     cand [MaxPattern][MaxSequence];
  int                  head [MaxPattern];
  int                  tail [MaxPattern];
  bit                  taken [MaxSequence];
  int                  seq_pos;
  int                  occ_total;

  tally_t    occ_expected [$];
  plan_row_t plan [$];
  bit        failed = 1'b0;
  int        src_idle_pct;
  int        snk_idle_pct;
  int        quiet_cycles = 0;

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void clear_matching();
    seq_pos   = 0;
    occ_total = 0;
    for (int m = 0; m < MaxPattern; m++) begin
      head[m] = 0;
      tail[m] = 0;
    end
    for (int p = 0; p < MaxSequence; p++) taken[p] = 1'b0;
  endfunction

  function automatic logic [7:0] pattern_char(int m);
    logic [CfgDataW-1:0] word;
    word = (m < 8) ? pat_low : pat_high;
    return word[(m % 8) * 8 +: 8];
  endfunction

  function automatic bit fifo_busy(int m);
    return head[m] < tail[m];
  endfunction

  function automatic int fifo_front(int m);
    return cand[m][head[m] % MaxSequence];
  endfunction

  // Appends one row to the directed plan.
  function automatic void add_row(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // Advances the matching state by one byte and returns its result.
  function automatic tally_t predict_byte(logic [7:0] sym, logic last);
    tally_t r;
    int     len;
    bit     all_ready;
    len = int'(pat_len);
    if (len < 1) len = 1;
    if (len > MaxPattern) len = MaxPattern;
    r = '0;
    r.is_last = last;
    if (seq_pos >= MaxSequence) begin
      r.overflow = 1'b1;
    end else begin
      for (int m = 0; m < len; m++) begin
        while (fifo_busy(m) && taken[fifo_front(m)]) head[m]++;
        if (m > 0) begin
          while (fifo_busy(m) && fifo_busy(m - 1) &&
                 (fifo_front(m) <= fifo_front(m - 1) || taken[fifo_front(m)]))
            head[m]++;
        end
        if (sym == pattern_char(m) && tail[m] < MaxSequence) begin
          if (m == 0 || (fifo_busy(m - 1) && seq_pos > fifo_front(m - 1))) begin
            cand[m][tail[m]] = PosW'(seq_pos);
            tail[m]++;
          end
        end
      end
      all_ready = 1'b1;
      for (int m = 0; m < len; m++) if (!fifo_busy(m)) all_ready = 1'b0;
      if (all_ready) begin
        for (int m = 0; m < len; m++) taken[fifo_front(m)] = 1'b1;
        occ_total++;
        r.found = 1'b1;
      end
      seq_pos++;
    end
    r.count = CntW'(occ_total);
    if (last) clear_matching();
    return r;
  endfunction

  // Sends one byte; the expectation is typed in or predicted.
  task automatic send_byte(input logic [7:0] sym, input logic last,
                           input bit typed, input tally_t want);
    tally_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.last   <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = predict_byte(sym, last);
    occ_expected.insert(occ_expected.size(), typed ? want : pred);
  endtask

  // Writes one register; the caller lowers valid afterwards.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CfgPatternLength:    pat_len = data[LenW-1:0];
      CfgPatternCharsLow:  pat_low = data;
      CfgPatternCharsHigh: pat_high = data;
      default: ;
    endcase
  endtask

  // Waits until every result is back and the clearing pass is over.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (occ_expected.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic load_pattern(input int len, input logic [CfgDataW-1:0] lo,
                              input logic [CfgDataW-1:0] hi);
    drain();
    write_reg(CfgPatternLength, CfgDataW'(len));
    write_reg(CfgPatternCharsLow, lo);
    write_reg(CfgPatternCharsHigh, hi);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random sequences, mostly drawn from the pattern characters.
  task automatic run_sequences(input int n_items, input int max_seq);
    int len;
    int seq_len;
    int sent;
    logic [7:0] s;
    len = int'(pat_len);
    if (len < 1) len = 1;
    if (len > MaxPattern) len = MaxPattern;
    sent = 0;
    while (sent < n_items) begin
      seq_len = $urandom_range(max_seq, 1);
      for (int i = 0; i < seq_len; i++) begin
        if ($urandom_range(99) < 80) s = pattern_char($urandom_range(len - 1));
        else s = 8'($urandom_range(255));
        send_byte(s, i == seq_len - 1, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (occ_expected.size() == 0) begin
        $display("%0t: unexpected result count=%0d found=%0b overflow=%0b is_last=%0b",
                 $time, out_ch.occurrence_count, out_ch.found, out_ch.overflow,
                 out_ch.is_last);
        failed <= 1'b1;
      end else begin
        tally_t e;
        e = occ_expected.pop_front();
        if (e.count !== out_ch.occurrence_count || e.found !== out_ch.found ||
            e.overflow !== out_ch.overflow || e.is_last !== out_ch.is_last) begin
          $display("%0t: mismatch expected count=%0d found=%0b overflow=%0b is_last=%0b",
                   $time, e.count, e.found, e.overflow, e.is_last);
          $display("%0t:          actual   count=%0d found=%0b overflow=%0b is_last=%0b",
                   $time, out_ch.occurrence_count, out_ch.found, out_ch.overflow,
                   out_ch.is_last);
          failed <= 1'b1;
        end
      end
    end
  end

  // Receiver stalls.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    logic [7:0]          base;
    int                  plen;
    src_idle_pct = 13;
    snk_idle_pct = 61;
    in_ch.valid  = 1'b0;
    in_ch.symbol = '0;
    in_ch.last   = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    pat_len  = LenW'(1);
    pat_low  = '0;
    pat_high = '0;
    clear_matching();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (DrainWait) @(posedge clk_i);

    // Directed plan: reset pattern, short pattern, length extremes, all-ones characters.
    add_row('{0, 0, 0, 8'h00, 0, 1, '{11'd1, 1'b1, 1'b0, 1'b0}});
    add_row('{0, 0, 0, 8'hFF, 0, 1, '{11'd1, 1'b0, 1'b0, 1'b0}});
    add_row('{0, 0, 0, 8'h00, 1, 1, '{11'd2, 1'b1, 1'b0, 1'b1}});
    add_row('{0, 0, 0, 8'h01, 1, 1, '{11'd0, 1'b0, 1'b0, 1'b1}});
    add_row('{1, CfgPatternLength, 64'd3, 0, 0, 0, '0});
    add_row('{1, CfgPatternCharsLow, 64'h434241, 0, 0, 0, '0});
    add_row('{1, CfgPatternCharsHigh, '1, 0, 0, 0, '0});
    add_row('{0, 0, 0, "A", 0, 0, '0});
    add_row('{0, 0, 0, "A", 0, 0, '0});
    add_row('{0, 0, 0, "B", 0, 0, '0});
    add_row('{0, 0, 0, "C", 0, 0, '0});
    add_row('{0, 0, 0, "C", 0, 0, '0});
    add_row('{0, 0, 0, "B", 0, 0, '0});
    add_row('{0, 0, 0, "C", 1, 0, '0});
    add_row('{1, CfgPatternLength, 64'd0, 0, 0, 0, '0});
    add_row('{0, 0, 0, "A", 1, 1, '{11'd1, 1'b1, 1'b0, 1'b1}});
    add_row('{1, CfgPatternLength, 64'd31, 0, 0, 0, '0});
    add_row('{1, CfgPatternCharsLow, '1, 0, 0, 0, '0});
    add_row('{0, 0, 0, 8'hFF, 0, 0, '0});
    add_row('{0, 0, 0, 8'h00, 0, 0, '0});
    add_row('{0, 0, 0, 8'hFF, 1, 0, '0});
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
        cfg_ch.valid <= 1'b0;
      end else begin
        send_byte(plan[i].sym, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    // Random phases with changing patterns and idling modes.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 61;
        snk_idle_pct = 13;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      base = 8'($urandom_range(255));
      lo = '0;
      hi = '0;
      for (int b = 0; b < 8; b++) begin
        lo[b*8 +: 8] = 8'(base + $urandom_range(2));
        hi[b*8 +: 8] = 8'(base + $urandom_range(2));
      end
      case (ph)
        0: plen = 2;
        1: plen = 16;
        2: plen = 5;
        3: plen = 31;
        4: plen = 1;
        5: plen = 8;
        6: plen = 2;
        default: plen = $urandom_range(16, 0);
      endcase
      load_pattern(plen, lo, hi);
      run_sequences(70, (ph == 1 || ph == 3) ? 60 : 30);
    end

    // Final drain and verdict.
    in_ch.valid <= 1'b0;
    while (occ_expected.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/opoc_pkg.sv
src/opoc_if.sv
src/opoc_ram.sv
src/one_off_pattern_occurrence_counter_top.sv
verif/testbench.sv
